// ===== src/wmfbl_pkg.sv =====
// Shared types, codes and constant checks for the metafile record scanner.
package wmfbl_pkg;

    localparam logic [15:0] CODE_DIB_LONG  = 16'h0f43;
    localparam logic [15:0] CODE_DIB_SHORT = 16'h0b41;
    localparam logic [3:0]  HDR_WORDS      = 4'd9;
    localparam logic [3:0]  BMP_LAST_POS   = 4'd10;
    localparam logic [3:0]  BMP_LEN_LONG   = 4'd11;
    localparam logic [3:0]  BMP_LEN_SHORT  = 4'd10;
    localparam logic [31:0] COUNT_MAX      = 32'hffff_ffff;
    localparam logic [31:0] COUNT_NEAR_MAX = 32'hffff_fffe;
    localparam logic [31:0] MIN_REC_SIZE   = 32'd2;
    localparam logic [31:0] BARE_REC_SIZE  = 32'd3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SIZE_LO,
        PH_SIZE_HI,
        PH_BODY,
        PH_BITMAP
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  step_index;
        logic [15:0] size_low_half;
        logic [31:0] words_left;
        logic [31:0] byte_counter;
        logic        first_word_pending;
        logic        long_variant;
        logic        done;
        logic        found;
    } scan_state_t;

    typedef struct packed {
        logic        finished;
        logic [31:0] bytes_consumed;
        logic        bitmap_found;
        logic        mismatch;
    } scan_result_t;

    // Header: 0x0001, 0x0009, 0x0300, any, any, 0, any, any, 0
    function automatic logic hdr_mismatch(input logic [3:0] k, input logic [15:0] w);
        logic bad;
        unique case (k)
            4'd0:    bad = (w != 16'h0001);
            4'd1:    bad = (w != 16'h0009);
            4'd2:    bad = (w != 16'h0300);
            4'd5:    bad = (w != 16'h0000);
            4'd8:    bad = (w != 16'h0000);
            default: bad = 1'b0;
        endcase
        return bad;
    endfunction

    // Stretch-DIB fields: 0x0020, 0x00cc, 0, w, h, 0, 0, w, h, 0, 0
    function automatic logic bmp_mismatch(input logic [3:0] pos, input logic [15:0] w);
        logic bad;
        unique case (pos)
            4'd0:                                 bad = (w != 16'h0020);
            4'd1:                                 bad = (w != 16'h00cc);
            4'd2, 4'd5, 4'd6, 4'd9, 4'd10:        bad = (w != 16'h0000);
            default:                              bad = 1'b0;
        endcase
        return bad;
    endfunction

endpackage

// ===== src/wmfbl_if.sv =====
// Valid/ready channels for stream words and scan results.
interface wmfbl_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

interface wmfbl_result_if;
    logic        valid;
    logic        ready;
    logic        finished;
    logic [31:0] bytes_consumed;
    logic        bitmap_found;
    logic        mismatch;

    modport source (output valid, output finished, output bytes_consumed,
                    output bitmap_found, output mismatch, input ready);
    modport sink (input valid, input finished, input bytes_consumed,
                  input bitmap_found, input mismatch, output ready);
endinterface

// ===== src/wmfbl_scan_core.sv =====
// Next-state and result logic for one stream word.
module wmfbl_scan_core
    import wmfbl_pkg::*;
(
    input  scan_state_t  cur,
    input  logic [15:0]  word,
    input  logic [31:0]  data_length,
    output scan_state_t  nxt,
    output scan_result_t res
);

    logic [31:0] bc_new;
    logic        rec_end_done;
    logic [3:0]  step_inc;
    logic [3:0]  hdr_k;
    logic [3:0]  bmp_pos;
    logic [31:0] size;
    logic        size_small;
    logic [31:0] wl_dec;
    logic        mm;

    always_comb
    begin
        bc_new       = (cur.byte_counter >= COUNT_NEAR_MAX) ? COUNT_MAX
                                                            : cur.byte_counter + 32'd2;
        // record end test without wrap
        rec_end_done = ({1'b0, bc_new} + 33'd1) >= {1'b0, data_length};
        step_inc     = cur.step_index + 4'd1;
        hdr_k        = (cur.step_index > 4'd8) ? 4'd8 : cur.step_index;
        bmp_pos      = cur.step_index
                       + {3'b000, (!cur.long_variant && cur.step_index >= 4'd2)};
        if (bmp_pos > BMP_LAST_POS)
        begin
            bmp_pos = BMP_LAST_POS;
        end
        size_small   = ({word, cur.size_low_half} < MIN_REC_SIZE);
        size         = size_small ? MIN_REC_SIZE : {word, cur.size_low_half};
        wl_dec       = (cur.words_left != 32'd0) ? cur.words_left - 32'd1 : cur.words_left;
        mm           = 1'b0;
        nxt          = cur;

        if (!cur.done)
        begin
            nxt.byte_counter = bc_new;
            unique case (cur.phase)
                PH_HEADER:
                begin
                    mm = hdr_mismatch(hdr_k, word);
                    nxt.step_index = step_inc;
                    if (step_inc >= HDR_WORDS)
                    begin
                        nxt.step_index = 4'd0;
                        nxt.phase      = PH_SIZE_LO;
                    end
                end
                PH_SIZE_LO:
                begin
                    nxt.size_low_half = word;
                    nxt.phase         = PH_SIZE_HI;
                end
                PH_SIZE_HI:
                begin
                    mm = size_small;
                    if (size == MIN_REC_SIZE)
                    begin
                        if (rec_end_done)
                        begin
                            nxt.done = 1'b1;
                        end
                        else
                        begin
                            nxt.phase = PH_SIZE_LO;
                        end
                    end
                    else
                    begin
                        nxt.words_left         = size - MIN_REC_SIZE;
                        nxt.first_word_pending = (size != BARE_REC_SIZE);
                        nxt.phase              = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    nxt.first_word_pending = 1'b0;
                    if (cur.first_word_pending
                        && (word == CODE_DIB_LONG || word == CODE_DIB_SHORT))
                    begin
                        nxt.long_variant = (word == CODE_DIB_LONG);
                        nxt.step_index   = 4'd0;
                        nxt.phase        = PH_BITMAP;
                    end
                    else
                    begin
                        nxt.words_left = wl_dec;
                        if (wl_dec == 32'd0)
                        begin
                            if (rec_end_done)
                            begin
                                nxt.done = 1'b1;
                            end
                            else
                            begin
                                nxt.phase = PH_SIZE_LO;
                            end
                        end
                    end
                end
                PH_BITMAP:
                begin
                    mm = bmp_mismatch(bmp_pos, word);
                    nxt.step_index = step_inc;
                    if (step_inc >= (cur.long_variant ? BMP_LEN_LONG : BMP_LEN_SHORT))
                    begin
                        nxt.done  = 1'b1;
                        nxt.found = 1'b1;
                    end
                end
                default:
                begin
                    nxt.phase = PH_HEADER;
                end
            endcase
        end

        res.finished       = nxt.done;
        res.bytes_consumed = nxt.byte_counter;
        res.bitmap_found   = nxt.found;
        res.mismatch       = mm;
    end

endmodule

// ===== src/metafile_header_bitmap_locator_unit.sv =====
// Top level: metafile header check and stretch-DIB record locator.
// One 16-bit word is taken per cycle; an accepted word is held in the input
// register and its result then goes into the result register, which offers it,
// unless a stalled result side keeps the word waiting in the input register.
// A word can be accepted every cycle as long as the result side keeps taking
// words. The per-word work is one pass of the scan logic on the held state,
// so the scan state loop sets the rate at one word per cycle. Each accepted
// word gives exactly one result word; after the scan has finished, words are
// still taken, answered with the held count and bitmap flag. The user is to
// write data_length through the configuration port while idle; unenforced.
module metafile_header_bitmap_locator_unit
    import wmfbl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    wmfbl_word_if.sink         stream,
    wmfbl_result_if.source     result,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data
);

    logic [31:0]  data_length_reg;
    logic         in_valid_reg;
    logic [15:0]  word_reg;
    scan_state_t  state_reg;
    scan_state_t  state_next;
    logic         out_valid_reg;
    scan_result_t out_reg;
    scan_result_t out_next;
    logic         advance;
    logic         take_in;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign stream.ready = !in_valid_reg || advance;
    assign take_in      = stream.valid && stream.ready;

    wmfbl_scan_core u_core (
        .cur         (state_reg),
        .word        (word_reg),
        .data_length (data_length_reg),
        .nxt         (state_next),
        .res         (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_length_reg <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '{phase: PH_HEADER, default: '0};
        end
        else
        begin
            if (cfg_wr_en)
            begin
                data_length_reg <= cfg_wr_data;
            end
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            word_reg <= stream.word;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.finished       = out_reg.finished;
    assign result.bytes_consumed = out_reg.bytes_consumed;
    assign result.bitmap_found   = out_reg.bitmap_found;
    assign result.mismatch       = out_reg.mismatch;

    // once finished, the scan stays finished
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.done |=> state_reg.done)
        else $error("scan left the finished state");

    // bitmap found only ever ends a scan
    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.found |-> state_reg.done)
        else $error("bitmap flag without finished");

    // byte count never goes back
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> state_reg.byte_counter >= $past(state_reg.byte_counter))
        else $error("byte count decreased");

    // a stalled result side holds the input stage full
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready && in_valid_reg) |=> in_valid_reg)
        else $error("held word dropped during stall");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for the metafile record scanner: header, record and stretch-DIB streams vs. a predictor.
module tb_top;
    import wmfbl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED = 40;
    // checked positions of the header and of the stretch-DIB fields
    localparam logic [8:0]  HDR_CHECKED = 9'h127;
    localparam logic [10:0] BMP_CHECKED = 11'h667;

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PATTERN,
        SINK_SPARSE
    } sink_mode_t;

    typedef enum logic [1:0] {
        END_AT_LENGTH,
        END_AT_ZERO_LENGTH,
        END_AT_LONG_DIB,
        END_AT_SHORT_DIB
    } end_kind_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    wmfbl_word_if   stream_ch ();
    wmfbl_result_if result_ch ();

    metafile_header_bitmap_locator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream      (stream_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // scanner model state
    phase_t      scan_phase;
    logic [3:0]  scan_step;
    logic [15:0] size_lo;
    logic [31:0] body_left;
    logic [31:0] byte_count;
    logic        code_pending;
    logic        dib_long;
    logic        scan_done;
    logic        dib_found;
    logic [31:0] length_limit;

    scan_result_t expected_q[$];
    int           error_count;
    int           cycle_count;

    // idling controls
    int          burst_left;
    int          gap_max;
    sink_mode_t  sink_mode;
    logic [7:0]  stall_pattern;
    int          hold_req;
    int          hold_seen;
    int          hold_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] header_value(input logic [3:0] k);
        case (k)
            4'd0:    return 16'h0001;
            4'd1:    return 16'h0009;
            4'd2:    return 16'h0300;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic logic [15:0] bitmap_value(input logic [3:0] pos);
        case (pos)
            4'd0:    return 16'h0020;
            4'd1:    return 16'h00cc;
            default: return 16'h0000;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] check failed: %s", $time, what);
    endtask

    task automatic close_record();
        if ({1'b0, byte_count} + 33'd1 >= {1'b0, length_limit})
            scan_done = 1'b1;
        else
            scan_phase = PH_SIZE_LO;
    endtask

    task automatic scan_word(input logic [15:0] w, output scan_result_t r);
        logic        mm;
        logic [31:0] rec_size;
        logic [3:0]  pos;
        mm = 1'b0;
        if (!scan_done)
        begin
            if (byte_count >= COUNT_NEAR_MAX)
                byte_count = COUNT_MAX;
            else
                byte_count = byte_count + 32'd2;
            case (scan_phase)
                PH_HEADER:
                begin
                    if (HDR_CHECKED[scan_step] && w != header_value(scan_step))
                        mm = 1'b1;
                    scan_step = scan_step + 4'd1;
                    if (scan_step >= HDR_WORDS)
                    begin
                        scan_step = 4'd0;
                        scan_phase = PH_SIZE_LO;
                    end
                end
                PH_SIZE_LO:
                begin
                    size_lo = w;
                    scan_phase = PH_SIZE_HI;
                end
                PH_SIZE_HI:
                begin
                    rec_size = {w, size_lo};
                    if (rec_size < MIN_REC_SIZE)
                    begin
                        mm = 1'b1;
                        rec_size = MIN_REC_SIZE;
                    end
                    if (rec_size == MIN_REC_SIZE)
                        close_record();
                    else
                    begin
                        body_left = rec_size - MIN_REC_SIZE;
                        code_pending = (rec_size != BARE_REC_SIZE);
                        scan_phase = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (code_pending && (w == CODE_DIB_LONG || w == CODE_DIB_SHORT))
                    begin
                        dib_long = (w == CODE_DIB_LONG);
                        code_pending = 1'b0;
                        scan_step = 4'd0;
                        scan_phase = PH_BITMAP;
                    end
                    else
                    begin
                        code_pending = 1'b0;
                        if (body_left != 0)
                            body_left = body_left - 32'd1;
                        if (body_left == 0)
                            close_record();
                    end
                end
                PH_BITMAP:
                begin
                    pos = scan_step;
                    // short form has no extra zero word at position two
                    if (!dib_long && pos >= 4'd2)
                        pos = pos + 4'd1;
                    if (pos > BMP_LAST_POS)
                        pos = BMP_LAST_POS;
                    if (BMP_CHECKED[pos] && w != bitmap_value(pos))
                        mm = 1'b1;
                    scan_step = scan_step + 4'd1;
                    if (scan_step >= (dib_long ? BMP_LEN_LONG : BMP_LEN_SHORT))
                    begin
                        scan_done = 1'b1;
                        dib_found = 1'b1;
                    end
                end
                default: scan_phase = PH_HEADER;
            endcase
        end
        r.finished = scan_done;
        r.bytes_consumed = byte_count;
        r.bitmap_found = dib_found;
        r.mismatch = mm;
    endtask

    // input monitor: every accepted word gets its expected result
    always @(posedge clk)
    begin : word_monitor
        scan_result_t r;
        if (rst_n && stream_ch.valid && stream_ch.ready)
        begin
            scan_word(stream_ch.word, r);
            expected_q.push_back(r);
        end
    end

    always @(posedge clk)
    begin : result_checker
        scan_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                want = expected_q.pop_front();
                if (result_ch.finished !== want.finished)
                    report_mismatch($sformatf("finished %b, want %b",
                        result_ch.finished, want.finished));
                if (result_ch.bytes_consumed !== want.bytes_consumed)
                    report_mismatch($sformatf("bytes_consumed %0d, want %0d",
                        result_ch.bytes_consumed, want.bytes_consumed));
                if (result_ch.bitmap_found !== want.bitmap_found)
                    report_mismatch($sformatf("bitmap_found %b, want %b",
                        result_ch.bitmap_found, want.bitmap_found));
                if (result_ch.mismatch !== want.mismatch)
                    report_mismatch($sformatf("mismatch %b, want %b",
                        result_ch.mismatch, want.mismatch));
            end
        end
    end

    // receiver: long hold-off on request, otherwise the current stall mode
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            case (sink_mode)
                SINK_ALWAYS:  result_ch.ready <= 1'b1;
                SINK_RANDOM:  result_ch.ready <= ($urandom_range(3, 0) != 0);
                SINK_PATTERN: result_ch.ready <= stall_pattern[cycle_count % 8];
                default:      result_ch.ready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic [15:0] w);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(gap_max, 0);
            if (gap > 0)
            begin
                stream_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(16, 1);
        end
        stream_ch.valid <= 1'b1;
        stream_ch.word <= w;
        do
            @(posedge clk);
        while (!stream_ch.ready);
        burst_left--;
    endtask

    // lets the monitor queue the last accepted word before waiting for the queue to empty
    task automatic wait_idle();
        stream_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_length(input logic [31:0] len);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        length_limit = len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int gap, input sink_mode_t mode);
        gap_max = gap;
        sink_mode = mode;
        stall_pattern = 8'($urandom) | 8'h01;
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(7, 0))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom_range(16'hffff, 0));
        endcase
    endfunction

    task automatic send_size(input logic [31:0] rec_size);
        send_word(rec_size[15:0]);
        send_word(rec_size[31:16]);
    endtask

    // body words; the first never opens a stretch-DIB record, later ones may hold a code
    task automatic send_body(input int n);
        logic [15:0] w;
        for (int i = 0; i < n; i++)
        begin
            w = rand_word();
            if (i == 0 && (w == CODE_DIB_LONG || w == CODE_DIB_SHORT))
                w = w ^ 16'h0001;
            else if (i > 0 && $urandom_range(15, 0) == 0)
                w = $urandom_range(1, 0) ? CODE_DIB_LONG : CODE_DIB_SHORT;
            send_word(w);
        end
    endtask

    task automatic send_header();
        logic [15:0] w;
        for (int k = 0; k < HDR_WORDS; k++)
        begin
            if (HDR_CHECKED[k])
            begin
                w = header_value(4'(k));
                if ($urandom_range(2, 0) == 0)
                    w = w ^ 16'($urandom_range(16'hffff, 1));
            end
            else
                w = rand_word();
            send_word(w);
        end
    endtask

    task automatic send_random_record();
        int kind;
        int rec_size;
        kind = $urandom_range(19, 0);
        if (kind < 2)
            send_size(32'($urandom_range(1, 0)));
        else if (kind < 4)
        begin
            // single body word: a code here is only skipped
            send_size(BARE_REC_SIZE);
            send_word($urandom_range(1, 0) ? CODE_DIB_LONG : rand_word());
        end
        else if (kind < 6)
        begin
            rec_size = $urandom_range(120, 30);
            send_size(32'(rec_size));
            send_body(rec_size - 2);
        end
        else
        begin
            rec_size = $urandom_range(12, 2);
            send_size(32'(rec_size));
            send_body(rec_size - 2);
        end
    endtask

    // about 13 words per record on average
    task automatic send_records(input int n_records);
        for (int i = 0; i < n_records; i++)
            send_random_record();
    endtask

    task automatic send_bitmap_record(input logic long_form);
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] w;
        hi = $urandom_range(1, 0) ? 16'h0000 : rand_word();
        lo = (hi == 16'h0000) ? 16'($urandom_range(16'hffff, 4)) : rand_word();
        send_size({hi, lo});
        send_word(long_form ? CODE_DIB_LONG : CODE_DIB_SHORT);
        for (int pos = 0; pos <= BMP_LAST_POS; pos++)
        begin
            if (!long_form && pos == 2)
                continue;
            if (BMP_CHECKED[pos])
            begin
                w = bitmap_value(4'(pos));
                if ($urandom_range(3, 0) == 0)
                    w = w ^ 16'($urandom_range(16'hffff, 1));
            end
            else
                w = rand_word();
            send_word(w);
        end
    endtask

    task automatic test_directed_stream();
        write_length(COUNT_MAX);
        set_idling(0, SINK_ALWAYS);
        send_header();
        send_size(MIN_REC_SIZE);
        send_size(32'd0);
        send_size(BARE_REC_SIZE);
        send_word(CODE_DIB_LONG);
        send_size(32'd4);
        send_word(16'h0000);
        send_word(16'hffff);
        send_size(32'd5);
        send_word(16'h1234);
        send_word(CODE_DIB_SHORT);
        send_word(16'h0000);
    endtask

    task automatic test_random_records(input int phase_no);
        sink_mode_t mode;
        mode = sink_mode_t'($urandom_range(3, 0));
        if (phase_no % 2 == 0)
            write_length(COUNT_MAX);
        else
            write_length(byte_count + 32'd1000 + 32'($urandom_range(50000, 0)));
        if (phase_no == 3)
            set_idling(0, SINK_ALWAYS);
        else
            set_idling($urandom_range(2, 0) == 0 ? 12 : 3, mode);
        send_records(6 + $urandom_range(2, 0));
    endtask

    task automatic test_backpressure();
        write_length(COUNT_MAX);
        set_idling(0, SINK_ALWAYS);
        hold_req++;
        send_records(8);
        wait_idle();
    endtask

    // record end two bytes short of the limit must not end the scan
    task automatic test_length_boundary();
        int rec_size;
        rec_size = $urandom_range(8, 2);
        write_length(byte_count + 32'(2 * rec_size) + 32'd2);
        set_idling(3, SINK_RANDOM);
        send_size(32'(rec_size));
        send_body(rec_size - 2);
    endtask

    task automatic test_scan_end();
        end_kind_t kind;
        int rec_size;
        kind = end_kind_t'($urandom_range(3, 0));
        rec_size = $urandom_range(8, 2);
        set_idling(3, SINK_RANDOM);
        case (kind)
            END_AT_LENGTH:
            begin
                write_length(byte_count + 32'(2 * rec_size) + 32'd1);
                send_size(32'(rec_size));
                send_body(rec_size - 2);
            end
            END_AT_ZERO_LENGTH:
            begin
                write_length(32'd0);
                send_size(32'(rec_size));
                send_body(rec_size - 2);
            end
            END_AT_LONG_DIB:
            begin
                write_length(32'd0);
                send_bitmap_record(1'b1);
            end
            default:
            begin
                write_length(32'd0);
                send_bitmap_record(1'b0);
            end
        endcase
        // words after the end are taken and answered with the held state
        set_idling(0, SINK_PATTERN);
        for (int i = 0; i < 30; i++)
            send_word(rand_word());
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 32'd0;
        stream_ch.valid = 1'b0;
        stream_ch.word = 16'd0;
        result_ch.ready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        burst_left = 0;
        gap_max = 0;
        sink_mode = SINK_ALWAYS;
        stall_pattern = 8'hff;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        scan_phase = PH_HEADER;
        scan_step = 4'd0;
        size_lo = 16'd0;
        body_left = 32'd0;
        byte_count = 32'd0;
        code_pending = 1'b0;
        dib_long = 1'b0;
        scan_done = 1'b0;
        dib_found = 1'b0;
        length_limit = 32'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_stream();
        for (int p = 0; p < 8; p++)
            test_random_records(p);
        test_backpressure();
        test_length_boundary();
        test_scan_end();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch("expected results left over");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
